@@ sv/fwc_pkg.sv @@
// fwc_pkg: shared types and constants for the queue with cancel by identifier.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none
package fwc_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int QTY_W   = 16;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_CANCEL = 3'd1,
    OP_POP    = 3'd2,
    OP_PEEK   = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
  } entry_t;

  // per-cycle move of the chain, shared by all cells
  typedef struct packed {
    logic push;    // write fresh entry at the tail slot
    logic drop;    // remove head, close the gap
    logic rotate;  // head goes to the tail slot, rest move up
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/fwc_if.sv @@
// fwc_if: valid/ready channels for command words and result words.
// Depends on fwc_pkg for field widths.
`default_nettype none
interface fwc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [fwc_pkg::OP_W-1:0]     operation;
  logic [fwc_pkg::QTY_W-1:0]    quantity_in;
  logic [fwc_pkg::ID_W-1:0]     cancel_id;

  modport source (output valid, output operation, output quantity_in,
                  output cancel_id, input ready);
  modport sink   (input valid, input operation, input quantity_in,
                  input cancel_id, output ready);
endinterface

interface fwc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fwc_pkg::STAT_W-1:0]   status;
  logic [fwc_pkg::ID_W-1:0]     entry_id;
  logic [fwc_pkg::QTY_W-1:0]    entry_quantity;
  logic                         last;

  modport source (output valid, output status, output entry_id,
                  output entry_quantity, output last, input ready);
  modport sink   (input valid, input status, input entry_id,
                  input entry_quantity, input last, output ready);
endinterface
`default_nettype wire

@@ sv/fwc_cell.sv @@
// fwc_cell: one slot of the queue chain, holding an identifier and quantity.
// Depends on fwc_pkg.
`default_nettype none
module fwc_cell (
  input  wire logic                clk,
  input  wire fwc_pkg::cell_ctrl_t ctrl,
  input  wire fwc_pkg::occ_t       occupancy,
  input  wire fwc_pkg::idx_t       index,
  input  wire fwc_pkg::entry_t     head,
  input  wire fwc_pkg::entry_t     right,
  input  wire fwc_pkg::entry_t     fresh,
  output fwc_pkg::entry_t          entry
);

  fwc_pkg::occ_t pos;
  fwc_pkg::occ_t pos_inc;

  assign pos     = fwc_pkg::occ_t'(index);
  assign pos_inc = pos + fwc_pkg::occ_t'(1);

  always_ff @(posedge clk) begin
    if (ctrl.push && pos == occupancy) begin
      entry <= fresh;
    end else if ((ctrl.rotate || ctrl.drop) && pos_inc < occupancy) begin
      entry <= right;
    end else if (ctrl.rotate && pos_inc == occupancy) begin
      entry <= head;
    end
  end

endmodule
`default_nettype wire

@@ sv/fifo_with_cancel_by_id.sv @@
// fifo_with_cancel_by_id: top level, bounded in-order queue with removal by id.
// Depends on fwc_pkg, fwc_if (fwc_cmd_if, fwc_rsp_if) and fwc_cell.
//
// Usage:
//  - cmd channel takes one command word: push, cancel, pop, peek or dump.
//    Codes 5..7 are swallowed with no result.
//  - rsp channel gives result words; every command but codes 5..7 ends with a
//    word that has last set. Dump gives one word per entry, oldest first.
//  - Storage is a chain of DEPTH cells, head (oldest) in cell 0. Each cycle
//    the chain can push at the tail, drop the head, or rotate the head round
//    to the tail slot.
//  - Push, pop, peek: the result is registered at acceptance.
//  - Cancel walks the whole queue by rotation, one entry per cycle, dropping
//    the oldest match as it passes the head; the result follows the walk.
//  - Dump rotates once per result word sent, so one word per cycle when the
//    receiver keeps ready high.
//  - One command at a time: cmd.ready is high only when idle and the output
//    register is free or being emptied.
//  - A receiver stall holds the output register and freezes dump rotation;
//    no word is lost.
//  - Reset (rst, synchronous): queue empty, next identifier 1, no pending
//    result. Cell contents are not cleared; slots beyond occupancy are never
//    read.
`default_nettype none
module fifo_with_cancel_by_id (
  input  wire logic  clk,
  input  wire logic  rst,
  fwc_cmd_if.sink    cmd,
  fwc_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DUMP
  } state_t;

  state_t                      state;
  fwc_pkg::occ_t               occupancy;
  fwc_pkg::occ_t               remaining;   // rotations or drops still to do
  logic [fwc_pkg::ID_W-1:0]    next_id;
  logic [fwc_pkg::ID_W-1:0]    want;
  logic                        found;
  fwc_pkg::entry_t             found_entry;

  // output register
  logic                        ov;
  logic [fwc_pkg::STAT_W-1:0]  o_status;
  logic [fwc_pkg::ID_W-1:0]    o_id;
  logic [fwc_pkg::QTY_W-1:0]   o_qty;
  logic                        o_last;

  fwc_pkg::entry_t             cells    [fwc_pkg::DEPTH];
  fwc_pkg::entry_t             rights   [fwc_pkg::DEPTH];
  fwc_pkg::entry_t             head;
  fwc_pkg::entry_t             fresh;
  fwc_pkg::cell_ctrl_t         ctrl;

  logic cmd_fire;
  logic out_free;
  logic is_empty;
  logic is_full;
  logic match;

  assign head     = cells[0];
  assign fresh    = '{id: next_id, qty: cmd.quantity_in};
  assign out_free = !ov || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign cmd_fire = cmd.valid && cmd.ready;
  assign is_empty = (occupancy == '0);
  assign is_full  = (occupancy == fwc_pkg::occ_t'(fwc_pkg::DEPTH));
  assign match    = (head.id == want) && !found;

  assign rsp.valid          = ov;
  assign rsp.status         = o_status;
  assign rsp.entry_id       = o_id;
  assign rsp.entry_quantity = o_qty;
  assign rsp.last           = o_last;

  // chain moves for this cycle
  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          case (cmd.operation)
            fwc_pkg::OP_PUSH: ctrl.push = !is_full;
            fwc_pkg::OP_POP:  ctrl.drop = !is_empty;
            default:          ctrl = '0;
          endcase
        end
      end
      S_SCAN: begin
        if (remaining != '0) begin
          ctrl.drop   = match;
          ctrl.rotate = !match;
        end
      end
      S_DUMP: begin
        ctrl.rotate = out_free;
      end
      default: ctrl = '0;
    endcase
  end

  // the chain; last cell feeds itself as right neighbour (never selected)
  for (genvar g = 0; g < fwc_pkg::DEPTH; g++) begin : g_cell
    if (g == fwc_pkg::DEPTH - 1) begin : g_tail
      assign rights[g] = cells[g];
    end else begin : g_mid
      assign rights[g] = cells[g+1];
    end

    fwc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupancy (occupancy),
      .index     (fwc_pkg::idx_t'(g)),
      .head      (head),
      .right     (rights[g]),
      .fresh     (fresh),
      .entry     (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      next_id   <= fwc_pkg::ID_W'(1);
      ov        <= 1'b0;
      remaining <= '0;
      found     <= 1'b0;
    end else begin
      if (rsp.ready) begin
        ov <= 1'b0;
      end

      if (ctrl.push) begin
        occupancy <= occupancy + fwc_pkg::occ_t'(1);
      end else if (ctrl.drop) begin
        occupancy <= occupancy - fwc_pkg::occ_t'(1);
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (cmd.operation)
              fwc_pkg::OP_PUSH: begin
                ov     <= 1'b1;
                o_last <= 1'b1;
                if (is_full) begin
                  o_status <= fwc_pkg::ST_FULL;
                  o_id     <= '0;
                  o_qty    <= '0;
                end else begin
                  o_status <= fwc_pkg::ST_OK;
                  o_id     <= next_id;
                  o_qty    <= cmd.quantity_in;
                  // identifier 0 is never handed out
                  if (next_id == '1) begin
                    next_id <= fwc_pkg::ID_W'(1);
                  end else begin
                    next_id <= next_id + fwc_pkg::ID_W'(1);
                  end
                end
              end
              fwc_pkg::OP_CANCEL: begin
                if (is_empty) begin
                  ov       <= 1'b1;
                  o_last   <= 1'b1;
                  o_status <= fwc_pkg::ST_EMPTY;
                  o_id     <= '0;
                  o_qty    <= '0;
                end else begin
                  state     <= S_SCAN;
                  remaining <= occupancy;
                  want      <= cmd.cancel_id;
                  found     <= 1'b0;
                end
              end
              fwc_pkg::OP_POP, fwc_pkg::OP_PEEK: begin
                ov     <= 1'b1;
                o_last <= 1'b1;
                if (is_empty) begin
                  o_status <= fwc_pkg::ST_EMPTY;
                  o_id     <= '0;
                  o_qty    <= '0;
                end else begin
                  o_status <= fwc_pkg::ST_OK;
                  o_id     <= head.id;
                  o_qty    <= head.qty;
                end
              end
              fwc_pkg::OP_DUMP: begin
                if (is_empty) begin
                  ov       <= 1'b1;
                  o_last   <= 1'b1;
                  o_status <= fwc_pkg::ST_EMPTY;
                  o_id     <= '0;
                  o_qty    <= '0;
                end else begin
                  state     <= S_DUMP;
                  remaining <= occupancy;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          // output register is known free here: it was free at acceptance
          if (remaining != '0) begin
            remaining <= remaining - fwc_pkg::occ_t'(1);
            if (match) begin
              found       <= 1'b1;
              found_entry <= head;
            end
          end else begin
            ov     <= 1'b1;
            o_last <= 1'b1;
            state  <= S_IDLE;
            if (found) begin
              o_status <= fwc_pkg::ST_OK;
              o_id     <= found_entry.id;
              o_qty    <= found_entry.qty;
            end else begin
              o_status <= fwc_pkg::ST_NOT_FOUND;
              o_id     <= '0;
              o_qty    <= '0;
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            ov        <= 1'b1;
            o_status  <= fwc_pkg::ST_OK;
            o_id      <= head.id;
            o_qty     <= head.qty;
            o_last    <= (remaining == fwc_pkg::occ_t'(1));
            remaining <= remaining - fwc_pkg::occ_t'(1);
            if (remaining == fwc_pkg::occ_t'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
